### rtl/mau_pkg.sv
// mau_pkg: request and result payload types for the modular arithmetic unit
// no dependencies
package mau_pkg;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_REM = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] left_operand;
		logic [31:0] right_operand;
	} req_t;

	typedef struct packed {
		logic [31:0] result_value;
		logic        divide_by_zero;
	} rsp_t;

	localparam logic [31:0] MODULUS_RESET = 32'd2;

endpackage

### rtl/modular_arithmetic_unit.sv
// modular_arithmetic_unit: pipelined add, subtract, multiply modulo a configured
// modulus, and plain remainder; depends on mau_pkg
//
// usage: requests enter on in_valid/in_stall/in_data, results leave on
// out_valid/out_stall/out_data, one result per request, in order.
// the modulus is written over the apb port (any address maps to it); the user
// writes it only while idle, which the block itself does not enforce.
// throughput: one request per cycle unless the output stalls. the operand reduction
// is a bit-serial restoring remainder unrolled into OPERAND_WIDTH stages, then one
// stage forms the sum, difference or product, then 2*OPERAND_WIDTH stages reduce it.
// a stall on the output freezes the whole pipeline; when the output register
// is empty or being taken, in_stall is low and a request enters every cycle.
// reset clears all valid bits and sets the modulus to 2.
module modular_arithmetic_unit #(
	parameter int OPERAND_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  mau_pkg::req_t        in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output mau_pkg::rsp_t        out_data,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [1:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam int W  = OPERAND_WIDTH;
	localparam int W2 = 2 * OPERAND_WIDTH;

	logic [31:0] modulus_q;
	logic        adv;

	function automatic logic [W-1:0] rstep(logic [W-1:0] r, logic b, logic [W-1:0] d);
		logic [W:0] t;
		t = {r, b};
		if (t >= {1'b0, d}) begin
			t = t - {1'b0, d};
		end
		return t[W-1:0];
	endfunction

	assign pready = 1'b1;
	assign prdata = modulus_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= mau_pkg::MODULUS_RESET;
		end else if (psel && penable && pwrite) begin
			modulus_q <= pwdata;
		end
	end

	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// operand reduction stages
	logic         v_s1   [0:W];
	logic [1:0]   op_s1  [0:W];
	logic [W-1:0] m_s1   [0:W];
	logic [W-1:0] da_s1  [0:W];
	logic [W-1:0] ra_s1  [0:W];
	logic [W-1:0] xa_s1  [0:W];
	logic [W-1:0] rb_s1  [0:W];
	logic [W-1:0] xb_s1  [0:W];
	logic         bz_s1  [0:W];
	logic         ml_s1  [0:W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1[0] <= 1'b0;
		end else if (adv) begin
			v_s1[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1[0] <= in_data.operation;
			m_s1[0]  <= modulus_q[W-1:0];
			da_s1[0] <= (in_data.operation == mau_pkg::OP_REM) ?
				in_data.right_operand[W-1:0] : modulus_q[W-1:0];
			ra_s1[0] <= '0;
			xa_s1[0] <= in_data.left_operand[W-1:0];
			rb_s1[0] <= '0;
			xb_s1[0] <= in_data.right_operand[W-1:0];
			bz_s1[0] <= (in_data.right_operand[W-1:0] == '0);
			ml_s1[0] <= (modulus_q[W-1:0] < W'(2));
		end
	end

	for (genvar k = 0; k < W; k++) begin : g_red
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s1[k+1] <= 1'b0;
			end else if (adv) begin
				v_s1[k+1] <= v_s1[k];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				op_s1[k+1] <= op_s1[k];
				m_s1[k+1]  <= m_s1[k];
				da_s1[k+1] <= da_s1[k];
				ra_s1[k+1] <= rstep(ra_s1[k], xa_s1[k][W-1], da_s1[k]);
				xa_s1[k+1] <= {xa_s1[k][W-2:0], 1'b0};
				rb_s1[k+1] <= rstep(rb_s1[k], xb_s1[k][W-1], m_s1[k]);
				xb_s1[k+1] <= {xb_s1[k][W-2:0], 1'b0};
				bz_s1[k+1] <= bz_s1[k];
				ml_s1[k+1] <= ml_s1[k];
			end
		end
	end

	// combine stage feeds the final reduction stages at index 0
	logic          v_s3   [0:W2];
	logic [1:0]    op_s3  [0:W2];
	logic [W-1:0]  m_s3   [0:W2];
	logic [W-1:0]  r_s3   [0:W2];
	logic [W2-1:0] x_s3   [0:W2];
	logic [W-1:0]  rm_s3  [0:W2];
	logic          bz_s3  [0:W2];
	logic          ml_s3  [0:W2];
	logic [W2-1:0] comb_val;

	always_comb begin
		case (op_s1[W])
			mau_pkg::OP_ADD: comb_val = W2'({1'b0, ra_s1[W]} + {1'b0, rb_s1[W]});
			mau_pkg::OP_SUB: comb_val = W2'({1'b0, ra_s1[W]} + {1'b0, m_s1[W]}
				- {1'b0, rb_s1[W]});
			mau_pkg::OP_MUL: comb_val = W2'(ra_s1[W]) * W2'(rb_s1[W]);
			default:         comb_val = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3[0] <= 1'b0;
		end else if (adv) begin
			v_s3[0] <= v_s1[W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s3[0] <= op_s1[W];
			m_s3[0]  <= m_s1[W];
			r_s3[0]  <= '0;
			x_s3[0]  <= comb_val;
			rm_s3[0] <= ra_s1[W];
			bz_s3[0] <= bz_s1[W];
			ml_s3[0] <= ml_s1[W];
		end
	end

	for (genvar k = 0; k < W2; k++) begin : g_fin
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s3[k+1] <= 1'b0;
			end else if (adv) begin
				v_s3[k+1] <= v_s3[k];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				op_s3[k+1] <= op_s3[k];
				m_s3[k+1]  <= m_s3[k];
				r_s3[k+1]  <= rstep(r_s3[k], x_s3[k][W2-1], m_s3[k]);
				x_s3[k+1]  <= {x_s3[k][W2-2:0], 1'b0};
				rm_s3[k+1] <= rm_s3[k];
				bz_s3[k+1] <= bz_s3[k];
				ml_s3[k+1] <= ml_s3[k];
			end
		end
	end

	// output register
	mau_pkg::rsp_t fin;

	always_comb begin
		fin = '0;
		if (op_s3[W2] == mau_pkg::OP_REM) begin
			fin.divide_by_zero = bz_s3[W2];
			fin.result_value   = bz_s3[W2] ? 32'd0 : 32'(rm_s3[W2]);
		end else begin
			fin.result_value   = ml_s3[W2] ? 32'd0 : 32'(r_s3[W2]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= v_s3[W2];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data <= fin;
		end
	end

endmodule
